FILE: rtl/core/gslf_pkg.sv
// Shared types and constants of the golden-section line fit.
package gslf_pkg;

  localparam int unsigned SseW = 37;
  localparam logic signed [15:0] SlopeLimit = 16'sd12288;
  localparam logic [15:0] InvPhiQ16 = 16'd40504;
  localparam int unsigned MaxSteps = 16;
  localparam logic signed [15:0] BestCInit = 16'sd12288;
  localparam logic signed [15:0] BestDInit = 16'sd28672;
  localparam logic [SseW-1:0] SseMax = {SseW{1'b1}};

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_TRIAL = 1'b1;

  // request to the error unit
  typedef struct packed {
    logic               start;
    logic signed [15:0] c;
    logic signed [15:0] d;
  } sse_req_t;

  typedef struct packed {
    logic            done;
    logic [SseW-1:0] sse;
  } sse_rsp_t;

endpackage

FILE: rtl/core/gslf_sse.sv
// Sum-of-squared-residuals unit over the sample memory, one sample a cycle.
module gslf_sse #(
  parameter int unsigned MAX_SAMPLES = 32,
  parameter int unsigned AW = 5,
  parameter int unsigned CW = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic signed [15:0]    wr_x,
  input  logic signed [15:0]    wr_y,
  input  logic [CW-1:0]         count,
  input  gslf_pkg::sse_req_t    req,
  output gslf_pkg::sse_rsp_t    rsp
);

  logic signed [15:0] x_mem [MAX_SAMPLES];
  logic signed [15:0] y_mem [MAX_SAMPLES];
  logic signed [15:0] rd_x_r, rd_y_r;

  logic               busy_r, busy_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               v1_r, v1_nxt;   // read data valid
  logic               v2_r, v2_nxt;   // product valid
  logic               v3_r, v3_nxt;   // square valid
  logic signed [15:0] c_r, d_r;
  logic signed [15:0] y2_r;
  logic signed [31:0] prod_r;
  logic [31:0]        sq_r;
  logic [gslf_pkg::SseW-1:0] acc_r, acc_nxt;
  logic               done_r, done_nxt;

  logic signed [19:0] cx_q12;
  logic signed [19:0] resid;
  logic signed [15:0] resid_sat;
  logic [gslf_pkg::SseW:0] acc_sum;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= wr_x;
      y_mem[wr_addr] <= wr_y;
    end
    rd_x_r <= x_mem[idx_r[AW-1:0]];
    rd_y_r <= y_mem[idx_r[AW-1:0]];
  end

  assign cx_q12 = 20'(prod_r >>> 12);
  assign resid  = 20'(y2_r) - cx_q12 - 20'(d_r);
  always_comb begin
    if (resid > 20'sd32767) begin
      resid_sat = 16'sh7FFF;
    end else if (resid < -20'sd32768) begin
      resid_sat = 16'sh8000;
    end else begin
      resid_sat = resid[15:0];
    end
  end
  assign acc_sum = {1'b0, acc_r} + (gslf_pkg::SseW + 1)'(sq_r);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    v1_nxt   = 1'b0;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (idx_r < count && idx_r < CW'(MAX_SAMPLES)) begin
        v1_nxt  = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end else if (!v1_r && !v2_r && !v3_r) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
    if (v3_r) begin
      acc_nxt = acc_sum[gslf_pkg::SseW] ? gslf_pkg::SseMax : acc_sum[gslf_pkg::SseW-1:0];
    end
    v2_nxt = v1_r;
    v3_nxt = v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      v1_r   <= v1_nxt;
      v2_r   <= v2_nxt;
      v3_r   <= v3_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      c_r <= req.c;
      d_r <= req.d;
    end
    prod_r <= c_r * rd_x_r;
    y2_r   <= rd_y_r;
    sq_r   <= 32'(resid_sat * resid_sat);
    acc_r  <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.sse  = acc_r;

endmodule

FILE: rtl/core/golden_section_line_fit.sv
// Top level of the golden-section line fit: sequencer, best-fit registers, stream ports.
//
// Input beats on the in_ channel are either loads (tuser bit 0 = 0) that write one
// (x, y) pair to the sample memory, or trials (tuser bit 0 = 1) carrying an offset d.
// tuser bit 1 is the restart flag: on a load it empties the store and resets the
// best fit to c = 3.0, d = 7.0 before writing. Loads give no result beat; each trial
// gives one out_ beat with the found slope, the best fit so far, its error and an
// improved flag.
// A trial runs up to 16 golden-section steps, each two error passes, plus the final
// pass and, when needed, a baseline pass. Every error pass walks the sample memory
// at one sample a cycle through a four-stage read/multiply/square/accumulate chain.
// A load leaves the sequencer idle and ready for the next beat.
// One item is handled at a time; in_tready is low while a trial runs or its result
// waits in the output register.
// After reset the store is empty and the best fit is (3.0, 7.0) with its error
// unknown. A stalled receiver holds the result beat and blocks new input.
module golden_section_line_fit #(
  parameter int unsigned MAX_SAMPLES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // sample_x[15:0], sample_y[31:16], offset_trial[47:32]
  input  logic [1:0]  in_tuser,   // operation[0], restart[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // found_slope[14:0], best_slope[30:15], best_offset[46:31],
                                  // best_error[83:47], improved[84]
  output logic        out_tuser   // unused flag, held low
);

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_E1    = 3'd1;
  localparam logic [2:0] S_E2    = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_BASE  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]         st_r, st_nxt;
  logic               issue_r, issue_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic signed [15:0] best_c_r, best_c_nxt, best_d_r, best_d_nxt;
  logic [gslf_pkg::SseW-1:0] best_sse_r, best_sse_nxt, e1_r, e1_nxt, ef_r, ef_nxt;
  logic               known_r, known_nxt;
  logic signed [15:0] lo_r, lo_nxt, hi_r, hi_nxt, c1_r, c1_nxt, c2_r, c2_nxt, d_r, d_nxt;
  logic signed [14:0] found_r, found_nxt;
  logic [4:0]         step_r, step_nxt;
  logic               imp_r, imp_nxt;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  gslf_pkg::sse_req_t req;
  gslf_pkg::sse_rsp_t rsp;

  logic               accept;
  logic               op;
  logic               rs;
  logic [CW-1:0]      cnt_base;
  logic signed [17:0] width;
  logic               keep_going;
  logic signed [17:0] cand_hi, cand_lo;
  logic signed [17:0] mid;
  logic [31:0]        step_prod;

  assign accept = in_tvalid && in_tready;
  assign op     = in_tuser[0];
  assign rs     = in_tuser[1];
  assign in_tready = (st_r == S_IDLE);
  assign cnt_base  = rs ? '0 : count_r;
  assign wr_en   = accept && (op == gslf_pkg::OP_LOAD) && (cnt_base < CW'(MAX_SAMPLES));
  assign wr_addr = cnt_base[AW-1:0];

  assign width      = 18'(hi_r) - 18'(lo_r);
  assign keep_going = (step_r < 5'(gslf_pkg::MaxSteps)) && ((width * 5) >= 18'sd4096);
  assign mid        = (18'(lo_r) + 18'(hi_r)) >>> 1;
  assign step_prod  = 32'(16'(2 * gslf_pkg::SlopeLimit)) * 32'(gslf_pkg::InvPhiQ16);

  function automatic logic signed [15:0] clampv(input logic signed [17:0] v,
                                                input logic signed [15:0] l,
                                                input logic signed [15:0] h);
    if (v < 18'(l)) begin
      return l;
    end else if (v > 18'(h)) begin
      return h;
    end
    return v[15:0];
  endfunction

  gslf_sse #(.MAX_SAMPLES(MAX_SAMPLES), .AW(AW), .CW(CW)) u_sse (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_x    (in_tdata[15:0]),
    .wr_y    (in_tdata[31:16]),
    .count   (count_r),
    .req     (req),
    .rsp     (rsp)
  );

  always_comb begin
    st_nxt = st_r; issue_nxt = 1'b0; count_nxt = count_r;
    best_c_nxt = best_c_r; best_d_nxt = best_d_r; best_sse_nxt = best_sse_r;
    known_nxt = known_r; lo_nxt = lo_r; hi_nxt = hi_r; c1_nxt = c1_r; c2_nxt = c2_r;
    d_nxt = d_r; found_nxt = found_r; step_nxt = step_r; imp_nxt = imp_r;
    e1_nxt = e1_r; ef_nxt = ef_r;
    cand_hi = '0; cand_lo = '0;
    req.start = issue_r; req.c = c1_r; req.d = d_r;
    case (st_r)
      S_E1: req.c = c1_r;
      S_E2: req.c = c2_r;
      S_FINAL: req.c = 16'(mid);
      S_BASE: begin req.c = best_c_r; req.d = best_d_r; end
      default: req.c = c1_r;
    endcase
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (op == gslf_pkg::OP_LOAD) begin
            if (rs) begin
              best_c_nxt = gslf_pkg::BestCInit;
              best_d_nxt = gslf_pkg::BestDInit;
              best_sse_nxt = '0;
            end
            count_nxt = (cnt_base < CW'(MAX_SAMPLES)) ? cnt_base + 1'b1 : cnt_base;
            known_nxt = 1'b0;
          end else begin
            d_nxt  = in_tdata[47:32];
            lo_nxt = -gslf_pkg::SlopeLimit;
            hi_nxt = gslf_pkg::SlopeLimit;
            c1_nxt = gslf_pkg::SlopeLimit - 16'(step_prod >> 16);
            c2_nxt = -gslf_pkg::SlopeLimit + 16'(step_prod >> 16);
            step_nxt = '0;
            st_nxt = S_E1; issue_nxt = 1'b1;
          end
        end
      end
      S_E1: begin
        if (issue_r) begin
          if (!keep_going) begin
            st_nxt = S_E2; step_nxt = 5'(gslf_pkg::MaxSteps);
          end
        end else if (rsp.done) begin
          e1_nxt = rsp.sse; st_nxt = S_E2; issue_nxt = 1'b1;
        end
        if (issue_r && !keep_going) begin
          found_nxt = 15'(mid); st_nxt = S_FINAL; issue_nxt = 1'b1;
        end
      end
      S_E2: begin
        if (rsp.done) begin
          if (e1_r > rsp.sse) begin
            lo_nxt = c1_r; c1_nxt = c2_r;
            cand_hi = 18'(hi_r) - (18'(c2_r) - 18'(c1_r));
            c2_nxt = clampv(cand_hi, c1_r, hi_r);
          end else begin
            hi_nxt = c2_r; c2_nxt = c1_r;
            cand_lo = 18'(lo_r) + (18'(c2_r) - 18'(c1_r));
            c1_nxt = clampv(cand_lo, lo_r, c2_r);
          end
          step_nxt = step_r + 1'b1;
          st_nxt = S_E1; issue_nxt = 1'b1;
        end
      end
      S_FINAL: begin
        if (!issue_r && rsp.done) begin
          ef_nxt = rsp.sse;
          if (known_r) begin
            imp_nxt = rsp.sse < best_sse_r;
            if (rsp.sse < best_sse_r) begin
              best_c_nxt = 16'(found_r); best_d_nxt = d_r; best_sse_nxt = rsp.sse;
            end
            known_nxt = 1'b1; st_nxt = S_OUT;
          end else begin
            st_nxt = S_BASE; issue_nxt = 1'b1;
          end
        end
      end
      S_BASE: begin
        if (!issue_r && rsp.done) begin
          imp_nxt = ef_r < rsp.sse;
          if (ef_r < rsp.sse) begin
            best_c_nxt = 16'(found_r); best_d_nxt = d_r; best_sse_nxt = ef_r;
          end else begin
            best_sse_nxt = rsp.sse;
          end
          known_nxt = 1'b1; st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; issue_r <= 1'b0; count_r <= '0;
      best_c_r <= gslf_pkg::BestCInit; best_d_r <= gslf_pkg::BestDInit;
      best_sse_r <= '0; known_r <= 1'b0; step_r <= '0;
    end else begin
      st_r <= st_nxt; issue_r <= issue_nxt; count_r <= count_nxt;
      best_c_r <= best_c_nxt; best_d_r <= best_d_nxt;
      best_sse_r <= best_sse_nxt; known_r <= known_nxt; step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt; hi_r <= hi_nxt; c1_r <= c1_nxt; c2_r <= c2_nxt; d_r <= d_nxt;
    found_r <= found_nxt; imp_r <= imp_nxt; e1_r <= e1_nxt; ef_r <= ef_nxt;
  end

  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {3'b000, imp_r, best_sse_r, best_d_r, best_c_r, found_r};
  assign out_tuser  = 1'b0;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SAMPLES)) else $error("sample count beyond store");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_tready) else $error("input taken while busy");
  a_known_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> known_r) else $error("result without known best error");
  a_slope_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (found_r <= 15'sd12288 && found_r >= -15'sd12288))
    else $error("found slope out of range");

endmodule

FILE: dv/golden_section_line_fit_tb.sv
// Self-checking testbench of the golden-section line fit, with its own slope-search predictor.
module golden_section_line_fit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 32;
  localparam int unsigned IdleLimit = 40000;
  localparam int unsigned RandItems = 1000;

  typedef struct packed {
    logic signed [14:0]          found_c;
    logic signed [15:0]          best_c;
    logic signed [15:0]          best_d;
    logic [gslf_pkg::SseW-1:0]   best_e;
    logic                        imp;
  } fit_res_t;

  typedef struct {
    fit_res_t res;
    bit       typed;
    fit_res_t typed_res;
  } fit_exp_t;

  typedef struct {
    logic               op;
    logic               rs;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] d;
    bit                 typed;
    fit_res_t           typed_res;
  } fit_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic        out_tuser;

  golden_section_line_fit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // predictor state
  logic signed [15:0]        px[Depth];
  logic signed [15:0]        py[Depth];
  int unsigned               n_pts;
  logic signed [15:0]        fit_c;
  logic signed [15:0]        fit_d;
  logic [gslf_pkg::SseW-1:0] fit_e;
  bit                        fit_e_known;

  fit_exp_t  fit_q[$];
  fit_exp_t  pending_typed[$];
  fit_row_t  dir_rows[$];
  int unsigned errors, n_loads, n_trials, n_improved, n_full, idle_cycles;
  int unsigned burst_left, rx_mode, rx_cnt;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [gslf_pkg::SseW-1:0] sq_error(longint c, longint d);
    longint r;
    logic [63:0] acc;
    acc = 0;
    for (int i = 0; i < n_pts; i++) begin
      r = longint'(py[i]) - ((c * longint'(px[i])) >>> 12) - d;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      acc += 64'(r * r);
      if (acc > 64'(gslf_pkg::SseMax)) acc = 64'(gslf_pkg::SseMax);
    end
    return acc[gslf_pkg::SseW-1:0];
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint golden_slope(longint d);
    longint lo, hi, step, c1, c2;
    lo = -longint'(gslf_pkg::SlopeLimit);
    hi = longint'(gslf_pkg::SlopeLimit);
    step = ((hi - lo) * longint'(gslf_pkg::InvPhiQ16)) >> 16;
    c1 = clip(hi - step, lo, hi);
    c2 = clip(lo + step, lo, hi);
    for (int n = 0; n < gslf_pkg::MaxSteps && 5 * (hi - lo) >= 4096; n++) begin
      if (sq_error(c1, d) > sq_error(c2, d)) begin
        lo = c1;
        c1 = c2;
        c2 = clip(hi - (c1 - lo), lo, hi);
      end else begin
        hi = c2;
        c2 = c1;
        c1 = clip(lo + (hi - c2), lo, hi);
      end
    end
    return ((lo + hi + 2 * longint'(gslf_pkg::SlopeLimit)) >> 1)
           - longint'(gslf_pkg::SlopeLimit);
  endfunction

  function automatic void fit_clear();
    n_pts = 0;
    fit_c = gslf_pkg::BestCInit;
    fit_d = gslf_pkg::BestDInit;
    fit_e = '0;
    fit_e_known = 1'b0;
  endfunction

  // apply one accepted beat; a trial leaves its expectation on the queue
  function automatic void fit_apply(logic [1:0] u, logic [47:0] dat);
    longint c, d;
    logic [gslf_pkg::SseW-1:0] e, base;
    fit_exp_t x;
    fit_exp_t tp;
    if (u[0] == gslf_pkg::OP_LOAD) begin
      n_loads++;
      if (u[1]) fit_clear();
      if (n_pts < Depth) begin
        px[n_pts] = dat[15:0];
        py[n_pts] = dat[31:16];
        n_pts++;
      end else begin
        n_full++;
      end
      fit_e_known = 1'b0;
    end else begin
      n_trials++;
      d = longint'($signed(dat[47:32]));
      c = golden_slope(d);
      e = sq_error(c, d);
      base = fit_e_known ? fit_e : sq_error(fit_c, fit_d);
      x.res.imp = e < base;
      if (x.res.imp) begin
        fit_c = 16'(c);
        fit_d = 16'(d);
        fit_e = e;
        n_improved++;
      end else begin
        fit_e = base;
      end
      fit_e_known = 1'b1;
      x.res.found_c = 15'(c);
      x.res.best_c = fit_c;
      x.res.best_d = fit_d;
      x.res.best_e = fit_e;
      x.typed = 1'b0;
      x.typed_res = '0;
      if (pending_typed.size() > 0) begin
        tp = pending_typed.pop_front();
        x.typed = 1'b1;
        x.typed_res = tp.typed_res;
      end
      fit_q.insert(fit_q.size(), x);
    end
  endfunction

  task automatic compare_beat(fit_res_t got, fit_res_t want);
    if (got.found_c !== want.found_c) begin
      $display("%0t: found_slope mismatch exp %0d got %0d", $time, want.found_c, got.found_c);
      errors++;
    end
    if (got.best_c !== want.best_c) begin
      $display("%0t: best_slope mismatch exp %0d got %0d", $time, want.best_c, got.best_c);
      errors++;
    end
    if (got.best_d !== want.best_d) begin
      $display("%0t: best_offset mismatch exp %0d got %0d", $time, want.best_d, got.best_d);
      errors++;
    end
    if (got.best_e !== want.best_e) begin
      $display("%0t: best_error mismatch exp %0d got %0d", $time, want.best_e, got.best_e);
      errors++;
    end
    if (got.imp !== want.imp) begin
      $display("%0t: improved mismatch exp %0b got %0b", $time, want.imp, got.imp);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) fit_apply(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        fit_res_t got;
        got.found_c = out_tdata[14:0];
        got.best_c = out_tdata[30:15];
        got.best_d = out_tdata[46:31];
        got.best_e = out_tdata[83:47];
        got.imp = out_tdata[84];
        if (fit_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_tdata);
          errors++;
        end else begin
          fit_exp_t w;
          w = fit_q.pop_front();
          compare_beat(got, w.res);
          if (w.typed) begin
            // found slope is not typed in, so take it from the predictor
            w.typed_res.found_c = w.res.found_c;
            compare_beat(got, w.typed_res);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, fit_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver: stall pattern is redrawn at random from four modes
  always @(negedge clk) begin
    if (rx_cnt == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_cnt = 64;
    end
    rx_cnt--;
    case (rx_mode)
      0: begin
        out_tready = 1'b1;
      end
      1: begin
        out_tready = $urandom_range(0, 1);
      end
      2: begin
        out_tready = ($urandom_range(0, 7) == 0);
      end
      default: begin
        out_tready = (rx_cnt % 5) != 0;
      end
    endcase
  end

  task automatic send(logic op, logic rs, logic [15:0] x, logic [15:0] y, logic [15:0] d);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = {rs, op};
    in_tdata = {d, y, x};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (fit_q.size() > 0) @(negedge clk);
  endtask

  function automatic void add_row(logic op, logic rs, int x, int y, int d, bit typed = 0,
                                  int bc = 0, int bd = 0, longint be = 0, bit imp = 0);
    fit_row_t r;
    r.op = op;
    r.rs = rs;
    r.x = 16'(x);
    r.y = 16'(y);
    r.d = 16'(d);
    r.typed = typed;
    r.typed_res.found_c = '0;
    r.typed_res.best_c = 16'(bc);
    r.typed_res.best_d = 16'(bd);
    r.typed_res.best_e = be[gslf_pkg::SseW-1:0];
    r.typed_res.imp = imp;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  initial begin
    fit_exp_t t;
    int unsigned sent, nload;
    fit_clear();
    errors = 0; n_loads = 0; n_trials = 0; n_improved = 0; n_full = 0;
    idle_cycles = 0; burst_left = 0; rx_cnt = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // empty store: every error is zero, best fit stays at its reset value
    add_row(gslf_pkg::OP_TRIAL, 0, 0, 0, 0, 1,
            gslf_pkg::BestCInit, gslf_pkg::BestDInit, 0, 0);
    // restart flag on a trial does nothing
    add_row(gslf_pkg::OP_TRIAL, 1, 0, 0, -32768, 1,
            gslf_pkg::BestCInit, gslf_pkg::BestDInit, 0, 0);
    add_row(gslf_pkg::OP_TRIAL, 0, 0, 0, 32767, 1,
            gslf_pkg::BestCInit, gslf_pkg::BestDInit, 0, 0);
    add_row(gslf_pkg::OP_LOAD, 1, 32767, -32768, 0);
    add_row(gslf_pkg::OP_LOAD, 0, -32768, 32767, 0);
    add_row(gslf_pkg::OP_LOAD, 0, 4096, 4096, 0);
    add_row(gslf_pkg::OP_TRIAL, 0, 0, 0, 0);
    add_row(gslf_pkg::OP_TRIAL, 0, 0, 0, 32767);
    add_row(gslf_pkg::OP_TRIAL, 0, 0, 0, -32768);
    add_row(gslf_pkg::OP_LOAD, 0, 0, 0, 0);
    add_row(gslf_pkg::OP_TRIAL, 0, 0, 0, 4096);
    // single sample at the origin, two trials at offset zero
    add_row(gslf_pkg::OP_LOAD, 1, 0, 0, 0);
    add_row(gslf_pkg::OP_TRIAL, 0, 0, 0, 0);
    add_row(gslf_pkg::OP_TRIAL, 0, 0, 0, 0);
    add_row(gslf_pkg::OP_LOAD, 0, 8192, 16384, 0);
    add_row(gslf_pkg::OP_LOAD, 0, -8192, -16384, 0);
    add_row(gslf_pkg::OP_TRIAL, 0, 0, 0, 0);
    add_row(gslf_pkg::OP_TRIAL, 0, 0, 0, 28672);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == gslf_pkg::OP_TRIAL && dir_rows[i].typed) begin
        t.typed_res = dir_rows[i].typed_res;
        pending_typed.insert(pending_typed.size(), t);
      end
      send(dir_rows[i].op, dir_rows[i].rs, dir_rows[i].x, dir_rows[i].y, dir_rows[i].d);
    end
    drain();

    // random part: fresh sample sets with random trials, some overfilling the store
    sent = 0;
    while (sent < RandItems) begin
      case ($urandom_range(0, 9))
        0: nload = $urandom_range(33, 36);
        1, 2: nload = $urandom_range(0, 2);
        default: nload = $urandom_range(2, 12);
      endcase
      begin
        int signed slope, icpt;
        slope = int'($urandom_range(0, 24576)) - 12288;
        icpt = int'($urandom_range(0, 16384)) - 8192;
        for (int i = 0; i < nload; i++) begin
          int signed xv, yv;
          if ($urandom_range(0, 4) == 0) begin
            xv = $urandom_range(0, 65535);
            yv = $urandom_range(0, 65535);
          end else begin
            xv = int'($urandom_range(0, 16384)) - 8192;
            yv = ((slope * xv) >>> 12) + icpt + int'($urandom_range(0, 512)) - 256;
          end
          send(gslf_pkg::OP_LOAD, i == 0 ? 1'b1 : ($urandom_range(0, 40) == 0),
               16'(xv), 16'(yv), 16'($urandom_range(0, 65535)));
          sent++;
        end
        repeat ($urandom_range(1, 5)) begin
          send(gslf_pkg::OP_TRIAL, $urandom_range(0, 1), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)),
               ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'(icpt + $urandom_range(0, 2048) - 1024));
          sent++;
        end
      end
      if ($urandom_range(0, 7) == 0) drain();
    end

    in_tvalid = 1'b0;
    while (fit_q.size() > 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    $display("Covered %0d loads (%0d past a full store) and %0d trials, %0d improving the fit.",
             n_loads, n_full, n_trials, n_improved);
    if (errors == 0 && fit_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
